/* src/nsf_pkg.sv */
// shared types, constants and helpers of the nmea sentence framer
package nsf_pkg;

   // buffer and field table limits
   localparam logic [7:0] MAX_BYTES  = 8'd128;
   localparam logic [4:0] MAX_FIELDS = 5'd25;

   // framing characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_DATA = 3'd1,
      PH_SUM1 = 3'd2,
      PH_SUM2 = 3'd3,
      PH_CR   = 3'd4,
      PH_LF   = 3'd5
   } nsf_phase_type;

   typedef struct packed {
      nsf_phase_type phase;
      logic [7:0]    run_xor;
      logic [7:0]    byte_idx;
      logic [4:0]    fields_seen;
   } nsf_state_type;

   typedef struct packed {
      logic       store_valid;
      logic [6:0] store_addr;
      logic [7:0] store_data;
      logic       field_start;
      logic [4:0] field_number;
      logic       sentence_done;
      logic [6:0] sentence_length;
      logic [4:0] field_count;
      logic       field_overflow;
      logic       byte_overflow;
      logic       checksum_error;
      logic       framing_error;
   } nsf_result_type;

   // upper-case ascii hex digit of one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib <= 4'd9) begin
         return wide + 8'h30;
      end
      return wide - 8'd10 + 8'h41;
   endfunction

endpackage

/* src/nsf_step.sv */
// per-byte sentence framing logic: next state and result of one byte
module nsf_step (
   input  nsf_pkg::nsf_state_type  cur_state,
   input  logic [7:0]              rx_byte,
   output nsf_pkg::nsf_state_type  nxt_state,
   output nsf_pkg::nsf_result_type result
);
   import nsf_pkg::*;

   logic [4:0] fields_inc;
   logic [7:0] idx_inc;

   assign fields_inc = cur_state.fields_seen + 5'd1;
   assign idx_inc    = cur_state.byte_idx + 8'd1;

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      case (cur_state.phase)
         PH_IDLE: begin
            if (rx_byte == CH_DOLLAR) begin
               nxt_state.byte_idx    = '0;
               nxt_state.fields_seen = 5'd1;
               nxt_state.run_xor     = '0;
               nxt_state.phase       = PH_DATA;
            end
         end
         PH_DATA: begin
            if (rx_byte == CH_STAR) begin
               nxt_state.phase = PH_SUM1;
            end else begin
               nxt_state.run_xor  = cur_state.run_xor ^ rx_byte;
               result.store_valid = 1'b1;
               result.store_addr  = cur_state.byte_idx[6:0];
               result.store_data  = rx_byte;
               if (rx_byte == CH_COMMA) begin
                  // separator stored as zero, opens the next field
                  result.store_data     = '0;
                  result.field_start    = 1'b1;
                  result.field_number   = cur_state.fields_seen;
                  nxt_state.fields_seen = fields_inc;
                  if (fields_inc >= MAX_FIELDS) begin
                     result.field_overflow = 1'b1;
                     nxt_state.phase       = PH_IDLE;
                  end
               end
               nxt_state.byte_idx = idx_inc;
               if (idx_inc >= MAX_BYTES) begin
                  result.byte_overflow = 1'b1;
                  nxt_state.phase      = PH_IDLE;
               end
            end
         end
         PH_SUM1: begin
            if (hex_digit(cur_state.run_xor[7:4]) == rx_byte) begin
               nxt_state.phase = PH_SUM2;
            end else begin
               result.checksum_error = 1'b1;
               nxt_state.phase       = PH_IDLE;
            end
         end
         PH_SUM2: begin
            if (hex_digit(cur_state.run_xor[3:0]) == rx_byte) begin
               nxt_state.phase = PH_CR;
            end else begin
               result.checksum_error = 1'b1;
               nxt_state.phase       = PH_IDLE;
            end
         end
         PH_CR: begin
            if (rx_byte == CH_CR) begin
               nxt_state.phase = PH_LF;
            end else begin
               result.framing_error = 1'b1;
               nxt_state.phase      = PH_IDLE;
            end
         end
         PH_LF: begin
            if (rx_byte == CH_LF) begin
               result.sentence_done   = 1'b1;
               result.sentence_length = cur_state.byte_idx[6:0];
               result.field_count     = cur_state.fields_seen;
            end else begin
               result.framing_error = 1'b1;
            end
            nxt_state.phase = PH_IDLE;
         end
         default: begin
            nxt_state.phase = PH_IDLE;
         end
      endcase
   end

endmodule

/* src/nsf_out_buf.sv */
// two-entry result buffer: output register plus skid register
module nsf_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  nsf_pkg::nsf_result_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output nsf_pkg::nsf_result_type out_data,
   input  logic                    out_ready
);
   import nsf_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   nsf_result_type out_data_ff, out_data_in;
   nsf_result_type skid_data_ff, skid_data_in;
   logic           push;
   logic           pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // skid moves up, new transfer lands in skid
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = in_data;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid only holds data behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   a_stall_push_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready && push) |=> skid_valid_ff)
      else $error("stalled transfer not caught by skid");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> out_valid_ff)
      else $error("skid entry lost on drain");

endmodule

/* src/nmea_sentence_framer.sv */
// nmea-0183 sentence framer top level: state registers, step logic, result buffer
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_store_* .. rsp_framing_error
//
// one byte per cycle while req_ready is high: each transfer on req updates the framing
// state and yields exactly one rsp transfer, held in the result register or the skid slot
// the rate is set by the combinational step logic between state and result registers
// reset is synchronous and active high; it returns the framer to idle and empties the buffer
// req_ready is registered; it drops only when both result slots are full
// a stall on rsp is absorbed by the skid slot, so req keeps flowing for one more byte
module nmea_sentence_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_store_valid,
   output logic [6:0] rsp_store_addr,
   output logic [7:0] rsp_store_data,
   output logic       rsp_field_start,
   output logic [4:0] rsp_field_number,
   output logic       rsp_sentence_done,
   output logic [6:0] rsp_sentence_length,
   output logic [4:0] rsp_field_count,
   output logic       rsp_field_overflow,
   output logic       rsp_byte_overflow,
   output logic       rsp_checksum_error,
   output logic       rsp_framing_error
);
   import nsf_pkg::*;

   // framing state: phase, running checksum, byte and field counters
   nsf_state_type  state_ff, state_in;
   nsf_state_type  step_state;
   nsf_result_type step_result;
   nsf_result_type out_result;
   logic           accept;

   assign accept = req_valid && req_ready;

   nsf_step u_step (
      .cur_state (state_ff),
      .rx_byte   (req_rx_byte),
      .nxt_state (step_state),
      .result    (step_result)
   );

   // state advances only on an accepted byte
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.run_xor     <= '0;
         state_ff.byte_idx    <= '0;
         state_ff.fields_seen <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // result register with skid slot toward rsp
   nsf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (step_result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_result),
      .out_ready (rsp_ready)
   );

   assign rsp_store_valid     = out_result.store_valid;
   assign rsp_store_addr      = out_result.store_addr;
   assign rsp_store_data      = out_result.store_data;
   assign rsp_field_start     = out_result.field_start;
   assign rsp_field_number    = out_result.field_number;
   assign rsp_sentence_done   = out_result.sentence_done;
   assign rsp_sentence_length = out_result.sentence_length;
   assign rsp_field_count     = out_result.field_count;
   assign rsp_field_overflow  = out_result.field_overflow;
   assign rsp_byte_overflow   = out_result.byte_overflow;
   assign rsp_checksum_error  = out_result.checksum_error;
   assign rsp_framing_error   = out_result.framing_error;

   // noise outside a sentence never opens one
   a_idle_noise: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_IDLE && req_rx_byte != CH_DOLLAR)
      |=> state_ff.phase == PH_IDLE)
      else $error("non-dollar byte left idle");

   // a sentence always has at least its first field open
   a_fields_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != PH_IDLE) |-> (state_ff.fields_seen != 5'd0))
      else $error("active sentence with no field");

   // the line feed slot always ends the sentence
   a_lf_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_LF) |=> state_ff.phase == PH_IDLE)
      else $error("sentence not closed after line feed slot");

endmodule

/* dv/tb_nmea_sentence_framer.sv */
// self-checking testbench of the nmea sentence framer: byte stimulus, framing predictor, checks
module tb_nmea_sentence_framer;
   import nsf_pkg::*;

   // kinds of sentence ending that the stimulus can produce
   typedef enum int {
      TAIL_GOOD   = 0,
      TAIL_BAD_HI = 1,
      TAIL_BAD_LO = 2,
      TAIL_LOWER  = 3,
      TAIL_BAD_CR = 4,
      TAIL_BAD_LF = 5,
      TAIL_CUT    = 6
   } tail_kind_type;

   localparam logic [8*16-1:0] HEX_ASCII = "0123456789ABCDEF";
   localparam logic [8*36-1:0] ALNUM     = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
   localparam int              STALL_CYCLES = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_store_valid;
   logic [6:0] rsp_store_addr;
   logic [7:0] rsp_store_data;
   logic       rsp_field_start;
   logic [4:0] rsp_field_number;
   logic       rsp_sentence_done;
   logic [6:0] rsp_sentence_length;
   logic [4:0] rsp_field_count;
   logic       rsp_field_overflow;
   logic       rsp_byte_overflow;
   logic       rsp_checksum_error;
   logic       rsp_framing_error;

   // framer state as the predictor sees it
   nsf_phase_type fr_phase = PH_IDLE;
   logic [7:0]    fr_xor = 8'h00;
   logic [7:0]    fr_count = 8'h00;
   logic [4:0]    fr_fields = 5'd0;

   // predicted results waiting for their rsp transfer, oldest first
   nsf_result_type pending_results[$];
   nsf_result_type rsp_seen;
   nsf_result_type rsp_wanted;

   // payload of the next sentence to send
   logic [7:0] body_bytes[$];

   // side-channel knobs for the two idling processes
   bit quiet_stretch = 1'b0;
   bit stall_request = 1'b0;
   int stall_left = 0;

   int error_count = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_done = 0;
   int n_field_ovf = 0;
   int n_byte_ovf = 0;
   int n_sum_err = 0;
   int n_frame_err = 0;

   nmea_sentence_framer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_store_valid     (rsp_store_valid),
      .rsp_store_addr      (rsp_store_addr),
      .rsp_store_data      (rsp_store_data),
      .rsp_field_start     (rsp_field_start),
      .rsp_field_number    (rsp_field_number),
      .rsp_sentence_done   (rsp_sentence_done),
      .rsp_sentence_length (rsp_sentence_length),
      .rsp_field_count     (rsp_field_count),
      .rsp_field_overflow  (rsp_field_overflow),
      .rsp_byte_overflow   (rsp_byte_overflow),
      .rsp_checksum_error  (rsp_checksum_error),
      .rsp_framing_error   (rsp_framing_error)
   );

   // 20-unit clock period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // upper-case ascii hex digit, taken from a character table
   function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
      int pos;
      pos = 15 - int'(nib);
      return HEX_ASCII[8*pos +: 8];
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] rnd;
      rnd = $urandom;
      return rnd[7:0];
   endfunction

   function automatic logic [7:0] any_byte_except(input logic [7:0] avoid);
      logic [7:0] pick;
      do pick = rand_byte(); while (pick == avoid);
      return pick;
   endfunction

   // one framing step: advances the predicted state and returns the result of this byte
   function automatic nsf_result_type frame_step(input logic [7:0] b);
      nsf_result_type r;
      logic [7:0]     stored;
      r = '0;
      case (fr_phase)
         PH_IDLE: begin
            // only a dollar opens a sentence, everything else is dropped silently
            if (b == CH_DOLLAR) begin
               fr_count  = 8'h00;
               fr_fields = 5'd1;
               fr_xor    = 8'h00;
               fr_phase  = PH_DATA;
            end
         end
         PH_DATA: begin
            if (b == CH_STAR) begin
               fr_phase = PH_SUM1;
            end else begin
               stored = b;
               fr_xor = fr_xor ^ b;
               if (b == CH_COMMA) begin
                  // separator is stored as zero and opens the next field
                  stored         = 8'h00;
                  r.field_start  = 1'b1;
                  r.field_number = fr_fields;
                  fr_fields      = fr_fields + 5'd1;
                  if (fr_fields >= MAX_FIELDS) begin
                     r.field_overflow = 1'b1;
                     fr_phase         = PH_IDLE;
                  end
               end
               r.store_valid = 1'b1;
               r.store_addr  = fr_count[6:0];
               r.store_data  = stored;
               fr_count      = fr_count + 8'd1;
               // both overflows can fire on the same byte
               if (fr_count >= MAX_BYTES) begin
                  r.byte_overflow = 1'b1;
                  fr_phase        = PH_IDLE;
               end
            end
         end
         PH_SUM1: begin
            if (b == ascii_hex(fr_xor[7:4])) begin
               fr_phase = PH_SUM2;
            end else begin
               r.checksum_error = 1'b1;
               fr_phase         = PH_IDLE;
            end
         end
         PH_SUM2: begin
            if (b == ascii_hex(fr_xor[3:0])) begin
               fr_phase = PH_CR;
            end else begin
               r.checksum_error = 1'b1;
               fr_phase         = PH_IDLE;
            end
         end
         PH_CR: begin
            if (b == CH_CR) begin
               fr_phase = PH_LF;
            end else begin
               r.framing_error = 1'b1;
               fr_phase        = PH_IDLE;
            end
         end
         PH_LF: begin
            if (b == CH_LF) begin
               r.sentence_done   = 1'b1;
               r.sentence_length = fr_count[6:0];
               r.field_count     = fr_fields;
            end else begin
               r.framing_error = 1'b1;
            end
            fr_phase = PH_IDLE;
         end
         default: begin
            fr_phase = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d field %s got %0d expected %0d",
                                   n_checked, name, got, want));
      end
   endtask

   task automatic check_result(input nsf_result_type got, input nsf_result_type want);
      check_field("store_valid",     int'(got.store_valid),     int'(want.store_valid));
      check_field("store_addr",      int'(got.store_addr),      int'(want.store_addr));
      check_field("store_data",      int'(got.store_data),      int'(want.store_data));
      check_field("field_start",     int'(got.field_start),     int'(want.field_start));
      check_field("field_number",    int'(got.field_number),    int'(want.field_number));
      check_field("sentence_done",   int'(got.sentence_done),   int'(want.sentence_done));
      check_field("sentence_length", int'(got.sentence_length),
                  int'(want.sentence_length));
      check_field("field_count",     int'(got.field_count),     int'(want.field_count));
      check_field("field_overflow",  int'(got.field_overflow),  int'(want.field_overflow));
      check_field("byte_overflow",   int'(got.byte_overflow),   int'(want.byte_overflow));
      check_field("checksum_error",  int'(got.checksum_error),  int'(want.checksum_error));
      check_field("framing_error",   int'(got.framing_error),   int'(want.framing_error));
   endtask

   // result side: check each rsp transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen = {rsp_store_valid, rsp_store_addr, rsp_store_data, rsp_field_start,
                     rsp_field_number, rsp_sentence_done, rsp_sentence_length,
                     rsp_field_count, rsp_field_overflow, rsp_byte_overflow,
                     rsp_checksum_error, rsp_framing_error};
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing predicted");
         end else begin
            rsp_wanted = pending_results.pop_front();
            check_result(rsp_seen, rsp_wanted);
         end
         n_checked++;
      end
      // a long hold-off, counted here, lets the block fill up and stall req
      if (stall_request) begin
         stall_left    = STALL_CYCLES;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
   end

   // one req transfer; valid stays up into the next byte unless a gap is taken
   task automatic send_byte(input logic [7:0] value);
      nsf_result_type predicted;
      if (!quiet_stretch && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      predicted = frame_step(value);
      pending_results.push_back(predicted);
      n_sent++;
      if (predicted.sentence_done)  n_done++;
      if (predicted.field_overflow) n_field_ovf++;
      if (predicted.byte_overflow)  n_byte_ovf++;
      if (predicted.checksum_error) n_sum_err++;
      if (predicted.framing_error)  n_frame_err++;
   endtask

   // fill body_bytes: commas at the given rate, else alphanumerics or, at wild_pct, any byte but a star
   task automatic build_body(input int len, input int comma_pct, input int wild_pct);
      logic [7:0] c;
      body_bytes.delete();
      repeat (len) begin
         if ($urandom_range(99) < comma_pct) begin
            c = CH_COMMA;
         end else if ($urandom_range(99) < wild_pct) begin
            c = any_byte_except(CH_STAR);
         end else begin
            c = ALNUM[8*$urandom_range(35) +: 8];
         end
         body_bytes.push_back(c);
      end
   endtask

   // dollar, body, then the checksum and line end, spoiled as the tail kind says
   task automatic send_sentence(input tail_kind_type tail);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] cr;
      logic [7:0] lf;
      sum = 8'h00;
      foreach (body_bytes[i]) sum = sum ^ body_bytes[i];
      hi = ascii_hex(sum[7:4]);
      lo = ascii_hex(sum[3:0]);
      cr = CH_CR;
      lf = CH_LF;
      case (tail)
         TAIL_BAD_HI: hi = ascii_hex(sum[7:4] + 4'd1);
         TAIL_BAD_LO: lo = ascii_hex(sum[3:0] ^ 4'd8);
         TAIL_LOWER: begin
            // digits are unchanged, letters become lower case
            hi = hi | 8'h20;
            lo = lo | 8'h20;
         end
         TAIL_BAD_CR: cr = any_byte_except(CH_CR);
         TAIL_BAD_LF: lf = any_byte_except(CH_LF);
         default: begin
         end
      endcase
      send_byte(CH_DOLLAR);
      foreach (body_bytes[i]) send_byte(body_bytes[i]);
      if (tail != TAIL_CUT) begin
         send_byte(CH_STAR);
         send_byte(hi);
         send_byte(lo);
         send_byte(cr);
         send_byte(lf);
      end
   endtask

   // bytes outside any sentence, framing characters among them
   task automatic test_idle_noise();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_STAR);
      send_byte(CH_COMMA);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(8'h80);
   endtask

   // empty payload: length zero, one field
   task automatic test_minimal_sentence();
      build_body(0, 0, 0);
      send_sentence(TAIL_GOOD);
   endtask

   // separators and a dollar inside the payload
   task automatic test_separators_and_dollar();
      body_bytes.delete();
      body_bytes.push_back(8'h41);
      body_bytes.push_back(CH_COMMA);
      body_bytes.push_back(CH_DOLLAR);
      body_bytes.push_back(CH_COMMA);
      send_sentence(TAIL_GOOD);
   endtask

   // checksum 7A sent as "7a" must be rejected
   task automatic test_lower_case_digits();
      body_bytes.delete();
      body_bytes.push_back(8'h7A);
      send_sentence(TAIL_LOWER);
   endtask

   task automatic test_every_ending();
      for (int k = TAIL_GOOD; k <= TAIL_CUT; k++) begin
         build_body(3, 30, 0);
         send_sentence(tail_kind_type'(k));
      end
   endtask

   // largest field count that fits, then a field table overflow
   task automatic test_field_limit();
      build_body(int'(MAX_FIELDS) - 2, 100, 0);
      send_sentence(TAIL_GOOD);
      build_body(30, 100, 0);
      send_sentence(TAIL_GOOD);
   endtask

   // longest payload that fits, both overflows on one byte, plain byte overflow
   task automatic test_byte_limit();
      build_body(int'(MAX_BYTES) - 1, 0, 0);
      send_sentence(TAIL_GOOD);
      build_body(int'(MAX_BYTES) - int'(MAX_FIELDS) + 1, 0, 0);
      repeat (int'(MAX_FIELDS) - 1) body_bytes.push_back(CH_COMMA);
      send_sentence(TAIL_GOOD);
      build_body(int'(MAX_BYTES) + 7, 0, 0);
      send_sentence(TAIL_GOOD);
   endtask

   // mostly well-formed sentences with random content, some broken, some line noise
   task automatic test_random_traffic(input int byte_budget);
      int stop_at;
      int len;
      int comma_pct;
      int wild_pct;
      tail_kind_type tail;
      stop_at = n_sent + byte_budget;
      while (n_sent < stop_at) begin
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(6, 1)) send_byte(rand_byte());
         end else begin
            len       = ($urandom_range(99) < 4) ? $urandom_range(135, 120)
                                                 : $urandom_range(30, 0);
            comma_pct = ($urandom_range(99) < 5) ? 90 : $urandom_range(30, 0);
            wild_pct  = ($urandom_range(99) < 15) ? 20 : 0;
            build_body(len, comma_pct, wild_pct);
            tail = ($urandom_range(99) < 70) ? TAIL_GOOD
                                             : tail_kind_type'($urandom_range(6, 1));
            send_sentence(tail);
         end
      end
   endtask

   // both sides always ready for a while
   task automatic test_no_idle_stretch();
      quiet_stretch = 1'b1;
      test_random_traffic(300);
      quiet_stretch = 1'b0;
   endtask

   // receiver holds off while bytes keep coming, so req_ready has to drop
   task automatic test_output_stall();
      stall_request = 1'b1;
      test_random_traffic(80);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_noise();
      test_minimal_sentence();
      test_separators_and_dollar();
      test_lower_case_digits();
      test_every_ending();
      test_field_limit();
      test_byte_limit();
      test_no_idle_stretch();
      test_output_stall();
      test_random_traffic(850);

      req_valid <= 1'b0;
      // drain, then keep clocking to catch any stray result
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d bytes and %0d result transfers, %0d sentences framed",
               n_sent, n_checked, n_done);
      $display("flags seen: %0d field overflow, %0d byte overflow, %0d checksum, %0d framing",
               n_field_ovf, n_byte_ovf, n_sum_err, n_frame_err);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
